@@ hdl/lprt_pkg.sv @@
// Shared types, constants and helpers for the longest-prefix route table.
`default_nettype none

package lprt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam logic       REQ_UPDATE = 1'b0;
    localparam logic       REQ_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ROUTE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [4:0] WITHDRAW_METRIC = 5'd16;
    localparam logic [4:0] METRIC_MAX      = 5'd31;
    localparam logic [5:0] MAX_PREFIX_LEN  = 6'd32;

    typedef struct packed {
        logic        req_type;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] hop_addr;
        logic [4:0]  metric;
        logic [7:0]  port;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] route_hop;
        logic [7:0]  route_port;
    } t_out_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_sts;

    // Network mask for a prefix length; lengths of 32 and more give all ones.
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len >= MAX_PREFIX_LEN) begin
            m = '1;
        end else begin
            m = ~(32'hFFFF_FFFF >> len);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hdl/lprt_ctrl.sv @@
// Sequencer for one request: accept, scan all entries, drain, commit.
`default_nettype none

module lprt_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  lprt_pkg::t_sts    i_sts,
    output lprt_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import lprt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/lprt_dp.sv @@
// Entry memories, scan compare, table update and response register.
`default_nettype none

module lprt_dp (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  lprt_pkg::t_cmd     i_cmd,
    input  lprt_pkg::t_in_req  i_in_req,
    input  wire                i_out_stall,
    output lprt_pkg::t_sts     o_sts,
    output logic               o_out_valid,
    output lprt_pkg::t_out_rsp o_out_rsp
);
    import lprt_pkg::*;

    // prefix entry: masked address, length; route entry: hop, port, metric
    logic [37:0]      m_prefix [ENTRIES];
    logic [44:0]      m_route  [ENTRIES];
    logic [ENTRIES-1:0] r_used;
    logic [ENTRIES-1:0] r_live;

    t_in_req          r_req;
    logic [37:0]      r_key;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_ridx;
    logic             r_rd_vld;
    logic [37:0]      r_pfx_q;
    logic [44:0]      r_rt_q;
    logic             r_used_q;
    logic             r_live_q;

    logic             r_best_found;
    logic [5:0]       r_best_len;
    logic [31:0]      r_best_hop;
    logic [7:0]       r_best_port;
    logic             r_hit_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic [4:0]       r_hit_met;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;

    logic             r_out_vld;
    t_out_rsp         r_out;

    logic [5:0]       cmp_len;
    logic             cmp_match;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_pfx;
    logic             wr_rt;
    logic             clr_live;
    logic [4:0]       stored_met;
    t_out_rsp         n_out;

    assign o_sts.scan_last = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid     = r_out_vld;
    assign o_out_rsp       = r_out;

    assign cmp_len   = r_pfx_q[5:0];
    assign cmp_match = (r_req.address & len_mask(cmp_len)) == r_pfx_q[37:6];

    // commit decision
    always_comb begin
        wr_idx     = r_hit_found ? r_hit_idx : r_free_idx;
        wr_pfx     = 1'b0;
        wr_rt      = 1'b0;
        clr_live   = 1'b0;
        stored_met = (r_req.metric >= METRIC_MAX) ? METRIC_MAX : r_req.metric + 5'd1;
        n_out      = '0;
        n_out.status = ST_OK;
        if (r_req.req_type == REQ_LOOKUP) begin
            if (r_best_found) begin
                n_out.route_hop  = r_best_hop;
                n_out.route_port = r_best_port;
            end else begin
                n_out.status = ST_NO_ROUTE;
            end
        end else if (r_req.prefix_len <= MAX_PREFIX_LEN) begin
            if (r_req.metric == WITHDRAW_METRIC) begin
                clr_live = r_hit_found;
            end else if (!r_hit_found && !r_free_found) begin
                n_out.status = ST_FULL;
            end else begin
                wr_pfx = !r_hit_found;
                wr_rt  = !r_hit_found || !r_live[wr_idx] || (r_req.metric < r_hit_met);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_pfx && i_cmd.commit) begin
            m_prefix[wr_idx] <= r_key;
        end
        if (wr_rt && i_cmd.commit) begin
            m_route[wr_idx] <= {r_req.hop_addr, r_req.port, stored_met};
        end
        r_pfx_q <= m_prefix[r_idx];
        r_rt_q  <= m_route[r_idx];
    end

    always_ff @(posedge i_clk) begin
        r_used_q <= r_used[r_idx];
        r_live_q <= r_live[r_idx];
        r_ridx   <= r_idx;
        if (i_cmd.load) begin
            r_req <= i_in_req;
            r_key <= {i_in_req.address & len_mask(i_in_req.prefix_len), i_in_req.prefix_len};
        end
        if (r_rd_vld && r_used_q && r_live_q && cmp_match
                && (!r_best_found || cmp_len > r_best_len)) begin
            r_best_len  <= cmp_len;
            r_best_hop  <= r_rt_q[44:13];
            r_best_port <= r_rt_q[12:5];
        end
        if (r_rd_vld && r_used_q && !r_hit_found && r_pfx_q == r_key) begin
            r_hit_idx <= r_ridx;
            r_hit_met <= r_rt_q[4:0];
        end
        if (r_rd_vld && !r_used_q && !r_free_found) begin
            r_free_idx <= r_ridx;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_live       <= '0;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx        <= '0;
                r_best_found <= 1'b0;
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_rd_vld && r_used_q && r_live_q && cmp_match) begin
                r_best_found <= 1'b1;
            end
            if (r_rd_vld && r_used_q && r_pfx_q == r_key) begin
                r_hit_found <= 1'b1;
            end
            if (r_rd_vld && !r_used_q) begin
                r_free_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (wr_pfx) begin
                    r_used[wr_idx] <= 1'b1;
                end
                if (wr_rt) begin
                    r_live[wr_idx] <= 1'b1;
                end
                if (clr_live) begin
                    r_live[r_hit_idx] <= 1'b0;
                end
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/longest_prefix_route_table_unit.sv @@
// Top level of the longest-prefix IPv4 route table.
// Each request (route update or lookup) is taken only while the unit is idle
// and then scans all ENTRIES table slots, one slot per cycle through the
// registered read port of the prefix and route memories; after a drain state
// the response is registered as soon as the output register is free, and the
// unit is then idle for the next request. A finished response waits in
// its output register while the next request is accepted and scanned. Update
// responses carry status only; a lookup returns the next hop and port of the
// longest live matching prefix, or no-route status. There is no clearing
// pass: slot-used and slot-live flags are flops cleared at reset.
`default_nettype none

module longest_prefix_route_table_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  lprt_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output lprt_pkg::t_out_rsp o_out_rsp
);
    import lprt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy;

    assign o_in_stall = busy;

    lprt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    lprt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

@@ hdl/lprt_checker.sv @@
// Port-level assertions for the route table, bound to the top level.
`default_nettype none

module lprt_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_stall,
    input lprt_pkg::t_out_rsp o_out_rsp,
    input wire                o_out_valid,
    input wire                i_out_stall
);
    import lprt_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while a scan is running");

    a_no_route_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.status != ST_OK
            |-> o_out_rsp.route_hop == 32'd0 && o_out_rsp.route_port == 8'd0)
        else $error("route fields set on a non-ok response");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_rsp.status == ST_OK || o_out_rsp.status == ST_NO_ROUTE
            || o_out_rsp.status == ST_FULL)
        else $error("bad status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled response changed");

endmodule

bind longest_prefix_route_table_unit lprt_checker u_lprt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_rsp   (o_out_rsp),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
